[rtl/stride2_trie_prefix_match_unit_macros.svh]
// ----------------------------------------------------------------------------
// stride2 trie prefix match unit assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STRIDE2_TRIE_PREFIX_MATCH_UNIT_MACROS_SVH
`define STRIDE2_TRIE_PREFIX_MATCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STPM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define STPM_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define STPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define STPM_ASSERT_ALWAYS(lbl, expr)
`define STPM_ASSERT_IMPLIES(lbl, ante, cons)
`define STPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/stpm_pkg.sv]
// ----------------------------------------------------------------------------
// stpm_pkg
// Shared constants, node layout and helper functions of the trie match unit.
// ----------------------------------------------------------------------------
package stpm_pkg;

  localparam int NODES        = 65536;
  localparam int NODE_RESERVE = 40;
  localparam int NODE_BITS    = $clog2(NODES);
  localparam int USED_W       = NODE_BITS + 1;
  localparam int LEVELS       = 16;
  localparam int LV_W         = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_VERIFY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [1:0] ENT_EVEN = 2'd0;
  localparam logic [1:0] ENT_ODD0 = 2'd1;

  // port entries hold port+1, zero means no route
  typedef struct packed {
    logic [3:0][NODE_BITS-1:0] link;
    logic [2:0][7:0]           port;
  } node_t;

  typedef struct packed {
    logic                 rd_en;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    node_t                wr_data;
  } mem_req_t;

  // two address bits consumed at a trie level, msb first
  function automatic logic [1:0] pair_at(input logic [31:0] addr, input logic [3:0] lv);
    logic [31:0] sh;
    sh = addr << {lv, 1'b0};
    return sh[31:30];
  endfunction

  // port entry that a route of the given length ends in
  function automatic logic [1:0] entry_sel(input logic [31:0] addr, input logic [5:0] len);
    logic [31:0] sh;
    sh = addr << (len - 6'd1);
    if (len[0]) begin
      return ENT_ODD0 + {1'b0, sh[31]};
    end
    return ENT_EVEN;
  endfunction

endpackage

[rtl/stpm_node_mem.sv]
// ----------------------------------------------------------------------------
// stpm_node_mem
// Simple dual-port node memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stpm_node_mem
  import stpm_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output node_t    rd_data
);

  node_t mem [NODES];
  node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/stride2_trie_prefix_match_unit.sv]
// ----------------------------------------------------------------------------
// stride2_trie_prefix_match_unit
// IPv4 longest-prefix match on a trie that consumes two address bits a level.
// ----------------------------------------------------------------------------
// One item (insert, lookup or verify) is worked on at a time. The trie walk
// reads one node per cycle from the node memory, whose registered read sets
// the pace. Each item passes from S_STEP to S_DONE and the result register,
// and the next item is taken once the unit is back in S_IDLE; rejected items
// skip S_STEP. A lookup or a full 32-bit route walks at most to depth 16, and a
// stalled result holds the unit until it drains. The root node lives in
// flip-flops and the other nodes are written in full when allocated, so the
// memory needs no clearing pass after reset. An insert is refused as table
// full when used_r plus NODE_RESERVE exceeds NODES, or when no node is left.
// ----------------------------------------------------------------------------
`include "stride2_trie_prefix_match_unit_macros.svh"

module stride2_trie_prefix_match_unit
  import stpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_length,
  input  logic [7:0]  in_port_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_found_port
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [31:0]          addr_r, addr_nxt;
  logic [7:0]           port_r, port_nxt;
  logic [LV_W-1:0]      depth_r, depth_nxt;
  logic [1:0]           ent_r, ent_nxt;
  logic [LV_W-1:0]      lv_r, lv_nxt;
  logic [NODE_BITS-1:0] cur_r, cur_nxt;
  node_t                node_r, node_nxt;
  node_t                root_r, root_nxt;
  logic                 ld_mem_r, ld_mem_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [7:0]           best_r, best_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [7:0]           fp_r, fp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [7:0]           out_port_r, out_port_nxt;

  mem_req_t             mreq;
  node_t                mem_rdata;

  node_t                node_w;
  node_t                node_mod;
  logic [1:0]           b;
  logic [NODE_BITS-1:0] child;
  logic [7:0]           e;
  logic [7:0]           odd;
  logic [7:0]           best_n;
  logic [NODE_BITS-1:0] new_idx;
  logic [5:0]           len_sat;
  logic                 wb;

  stpm_node_mem u_node_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (mem_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_port = out_port_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    port_nxt       = port_r;
    depth_nxt      = depth_r;
    ent_nxt        = ent_r;
    lv_nxt         = lv_r;
    cur_nxt        = cur_r;
    node_nxt       = node_r;
    root_nxt       = root_r;
    ld_mem_nxt     = ld_mem_r;
    fresh_nxt      = fresh_r;
    best_nxt       = best_r;
    used_nxt       = used_r;
    st_nxt         = st_r;
    fp_nxt         = fp_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_port_nxt   = out_port_r;
    mreq           = '0;
    wb             = 1'b0;

    node_w   = ld_mem_r ? mem_rdata : node_r;
    node_mod = node_w;
    b        = pair_at(addr_r, lv_r[3:0]);
    child    = node_w.link[b];
    e        = node_w.port[ent_r];
    odd      = node_w.port[ENT_ODD0 + {1'b0, b[1]}];
    best_n   = best_r;
    new_idx  = used_r[NODE_BITS-1:0] + 1'b1;
    len_sat  = (in_prefix_length > 6'd32) ? 6'd32 : in_prefix_length;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          addr_nxt   = in_address;
          port_nxt   = in_port_number;
          depth_nxt  = (in_operation == OP_LOOKUP) ? LV_W'(LEVELS) : len_sat[5:1];
          ent_nxt    = entry_sel(in_address, len_sat);
          lv_nxt     = '0;
          cur_nxt    = '0;
          node_nxt   = root_r;
          ld_mem_nxt = 1'b0;
          fresh_nxt  = 1'b0;
          best_nxt   = '0;
          fp_nxt     = '0;
          state_nxt  = S_STEP;
          if (in_operation != OP_LOOKUP && in_operation != OP_INSERT &&
              in_operation != OP_VERIFY) begin
            st_nxt    = ST_NONE;
            state_nxt = S_DONE;
          end else if (in_operation != OP_LOOKUP && in_port_number == 8'hFF) begin
            // port+1 would not fit an entry
            st_nxt    = ST_NONE;
            state_nxt = S_DONE;
          end else if (in_operation == OP_INSERT &&
                       ({1'b0, used_r} + (USED_W+1)'(NODE_RESERVE) >
                        (USED_W+1)'(NODES))) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end
        end
      end

      S_STEP: begin
        unique case (op_r)
          OP_LOOKUP: begin
            if (node_w.port[ENT_EVEN] != 8'd0) begin
              best_n = node_w.port[ENT_EVEN];
            end
            if (lv_r != depth_r && odd != 8'd0) begin
              best_n = odd;
            end
            best_nxt = best_n;
            if (lv_r == depth_r || child == '0) begin
              st_nxt    = (best_n == 8'd0) ? ST_NONE : ST_OK;
              fp_nxt    = (best_n == 8'd0) ? 8'd0 : best_n - 8'd1;
              state_nxt = S_DONE;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = child;
              cur_nxt      = child;
              ld_mem_nxt   = 1'b1;
              lv_nxt       = lv_r + 1'b1;
            end
          end

          OP_VERIFY: begin
            if (lv_r == depth_r) begin
              st_nxt    = (e != 8'd0 && e == port_r + 8'd1) ? ST_OK : ST_NONE;
              state_nxt = S_DONE;
            end else if (child == '0) begin
              st_nxt    = ST_NONE;
              state_nxt = S_DONE;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = child;
              cur_nxt      = child;
              ld_mem_nxt   = 1'b1;
              lv_nxt       = lv_r + 1'b1;
            end
          end

          OP_INSERT: begin
            if (lv_r == depth_r) begin
              if (e != 8'd0) begin
                st_nxt = ST_DUP;
              end else begin
                node_mod.port[ent_r] = port_r + 8'd1;
                wb     = 1'b1;
                st_nxt = ST_OK;
              end
              state_nxt = S_DONE;
            end else if (child != '0) begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = child;
              cur_nxt      = child;
              ld_mem_nxt   = 1'b1;
              lv_nxt       = lv_r + 1'b1;
            end else if (used_r + 1'b1 >= USED_W'(NODES)) begin
              // a freshly linked node must still land in memory as all zero
              wb        = fresh_r;
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              node_mod.link[b] = new_idx;
              wb         = 1'b1;
              used_nxt   = {1'b0, new_idx};
              cur_nxt    = new_idx;
              node_nxt   = '0;
              ld_mem_nxt = 1'b0;
              fresh_nxt  = 1'b1;
              lv_nxt     = lv_r + 1'b1;
            end
          end

          default: begin
            st_nxt    = ST_NONE;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_port_nxt   = fp_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // write back the current node, root held in flops
    if (wb) begin
      if (cur_r == '0) begin
        root_nxt = node_mod;
      end else begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = cur_r;
        mreq.wr_data = node_mod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      lv_r        <= '0;
      ld_mem_r    <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      lv_r        <= lv_nxt;
      ld_mem_r    <= ld_mem_nxt;
      fresh_r     <= fresh_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    port_r       <= port_nxt;
    depth_r      <= depth_nxt;
    ent_r        <= ent_nxt;
    cur_r        <= cur_nxt;
    node_r       <= node_nxt;
    best_r       <= best_nxt;
    st_r         <= st_nxt;
    fp_r         <= fp_nxt;
    out_status_r <= out_status_nxt;
    out_port_r   <= out_port_nxt;
  end

  `STPM_ASSERT_IMPLIES(a_mem_no_root, mreq.wr_en, mreq.wr_addr != '0)
  `STPM_ASSERT_IMPLIES(a_miss_port_zero, out_valid_r && out_status_r != ST_OK, out_port_r == 8'd0)
  `STPM_ASSERT_NEXT(a_used_step, 1'b1, (used_r == $past(used_r)) || (used_r == $past(used_r) + 1'b1))
  `STPM_ASSERT_ALWAYS(a_level_range, lv_r <= depth_r || state_r != S_STEP)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stride-2 trie prefix match unit. Routes are
// inserted, looked up and verified against a behavioral copy of the trie kept
// inside the bench, and every result is compared in order. A closing phase
// mixes duplicate inserts, bad ports and lookups near known routes.
// ----------------------------------------------------------------------------
module tb;
  import stpm_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [7:0]  port;
  } route_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] port;
  } match_res_t;

  // operation code that the unit does not know
  localparam logic [1:0] OP_INVALID = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_INSERT;
  logic [31:0] in_address = '0;
  logic [5:0]  in_prefix_length = '0;
  logic [7:0]  in_port_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_found_port;

  stride2_trie_prefix_match_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_address      (in_address),
    .in_prefix_length(in_prefix_length),
    .in_port_number  (in_port_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_port  (out_found_port)
  );

  always #6 clk = ~clk;

  // bench copy of the trie
  int unsigned trie_child [NODES][4];
  bit [7:0]    route_ent [NODES][3];
  int unsigned alloc_count = 0;

  route_req_t  pending_q[$];
  match_res_t  want_q[$];
  route_req_t  known_routes[$];

  bit          in_took = 1'b0;
  int unsigned accepted_items = 0;
  int unsigned checked_results = 0;
  int unsigned mismatches = 0;
  int unsigned ops_sent [4];
  int unsigned status_seen [4];
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  function automatic int unsigned addr_pair(input logic [31:0] addr, input int unsigned lv);
    return (addr >> (30 - 2 * lv)) & 32'd3;
  endfunction

  // even entry, or one of the two odd entries picked by the last route bit
  function automatic int unsigned route_slot(input logic [31:0] addr, input int unsigned len);
    if (len % 2 == 1) begin
      return 1 + ((addr >> (32 - len)) & 32'd1);
    end
    return 0;
  endfunction

  function automatic void predict_match(input route_req_t rq, output match_res_t res);
    int unsigned len;
    int unsigned cur;
    int unsigned lv;
    int unsigned pr;
    int unsigned slot;
    int unsigned best;
    res.status = ST_NONE;
    res.port   = '0;
    len = (rq.len > 6'd32) ? 32 : 32'(rq.len);
    cur = 0;
    case (rq.op)
      OP_INSERT: begin
        if (rq.port == 8'hFF) return;
        if (alloc_count + NODE_RESERVE > NODES) begin
          res.status = ST_FULL;
          return;
        end
        for (lv = 0; lv < len / 2; lv++) begin
          pr = addr_pair(rq.addr, lv);
          if (trie_child[cur][pr] == 0) begin
            if (alloc_count + 1 >= NODES) begin
              res.status = ST_FULL;
              return;
            end
            alloc_count++;
            trie_child[cur][pr] = alloc_count;
          end
          cur = trie_child[cur][pr];
        end
        slot = route_slot(rq.addr, len);
        if (route_ent[cur][slot] != 0) begin
          res.status = ST_DUP;
        end else begin
          route_ent[cur][slot] = rq.port + 8'd1;
          res.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        // root default route counts as the shortest match
        best = 32'(route_ent[0][0]);
        for (lv = 0; lv < LEVELS; lv++) begin
          pr = addr_pair(rq.addr, lv);
          if (route_ent[cur][1 + pr / 2] != 0) best = 32'(route_ent[cur][1 + pr / 2]);
          cur = trie_child[cur][pr];
          if (cur == 0) break;
          if (route_ent[cur][0] != 0) best = 32'(route_ent[cur][0]);
        end
        if (best != 0) begin
          res.status = ST_OK;
          res.port   = 8'(best - 1);
        end
      end
      OP_VERIFY: begin
        if (rq.port == 8'hFF) return;
        for (lv = 0; lv < len / 2; lv++) begin
          cur = trie_child[cur][addr_pair(rq.addr, lv)];
          if (cur == 0) return;
        end
        slot = route_slot(rq.addr, len);
        if (route_ent[cur][slot] != 0 && route_ent[cur][slot] == rq.port + 8'd1) begin
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit quiet_window();
    return accepted_items >= 600 && accepted_items < 900;
  endfunction

  function automatic bit sender_pause();
    if (quiet_window() || hold_left > 0) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  // input side: drive at the falling edge, hold while stalled
  always @(negedge clk) begin
    route_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_q.size() > 0 && !sender_pause()) begin
        nxt = pending_q.pop_front();
        in_valid         <= 1'b1;
        in_operation     <= nxt.op;
        in_address       <= nxt.addr;
        in_prefix_length <= nxt.len;
        in_port_number   <= nxt.port;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && accepted_items >= 300) begin
      hold_used <= 1'b1;
      hold_left <= 250;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_window() && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    route_req_t rq;
    match_res_t res;
    if (rst_n && in_valid && !in_stall) begin
      rq.op   = in_operation;
      rq.addr = in_address;
      rq.len  = in_prefix_length;
      rq.port = in_port_number;
      predict_match(rq, res);
      want_q.push_back(res);
      ops_sent[rq.op]++;
      accepted_items++;
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
  end

  always @(posedge clk) begin
    match_res_t res;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_status]++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d port %0d", out_status, out_found_port);
      end else begin
        res = want_q.pop_front();
        if (out_status !== res.status || out_found_port !== res.port) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d port %0d, got status %0d port %0d",
                     checked_results, res.status, res.port, out_status, out_found_port);
        end
      end
      checked_results++;
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [31:0] addr,
                          input logic [5:0] len, input logic [7:0] port);
    route_req_t rq;
    rq.op   = op;
    rq.addr = addr;
    rq.len  = len;
    rq.port = port;
    pending_q.push_back(rq);
    if (op == OP_INSERT && port != 8'hFF) begin
      known_routes.push_back(rq);
      if (known_routes.size() > 256) void'(known_routes.pop_front());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || want_q.size() != 0 || in_valid);
  endtask

  function automatic logic [31:0] near_addr(input route_req_t rq);
    int unsigned l;
    logic [31:0] mask;
    l = (rq.len > 6'd32) ? 32 : 32'(rq.len);
    mask = (l == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - l));
    return (rq.addr & mask) | ($urandom & ~mask);
  endfunction

  function automatic logic [5:0] pick_len(input bit allow_zero);
    case ($urandom_range(9))
      0:       return allow_zero ? 6'($urandom_range(7)) : 6'($urandom_range(7, 1));
      1:       return 6'($urandom_range(63, 33));
      default: return 6'($urandom_range(32, 8));
    endcase
  endfunction

  task automatic add_random(input bit allow_zero);
    route_req_t kr;
    int unsigned k;
    k = $urandom_range(99);
    if (known_routes.size() > 0) kr = known_routes[$urandom_range(known_routes.size() - 1)];
    if (k < 35) begin
      if (k < 5 && known_routes.size() > 0)
        add_item(OP_INSERT, kr.addr, kr.len, 8'($urandom_range(254)));
      else
        add_item(OP_INSERT, $urandom, pick_len(allow_zero), 8'($urandom_range(254)));
    end else if (k < 70) begin
      if (known_routes.size() > 0 && $urandom_range(3) != 0)
        add_item(OP_LOOKUP, near_addr(kr), 6'($urandom_range(63)), 8'($urandom_range(255)));
      else
        add_item(OP_LOOKUP, $urandom, 6'($urandom_range(63)), 8'($urandom_range(255)));
    end else if (k < 93 && known_routes.size() > 0) begin
      case ($urandom_range(3))
        0, 1: add_item(OP_VERIFY, kr.addr, kr.len, kr.port);
        2:    add_item(OP_VERIFY, kr.addr, kr.len, 8'($urandom_range(254)));
        default: add_item(OP_VERIFY, near_addr(kr), pick_len(1'b1), kr.port);
      endcase
    end else begin
      case ($urandom_range(2))
        0:       add_item(OP_INVALID, $urandom, 6'($urandom_range(63)),
                          8'($urandom_range(255)));
        1:       add_item(OP_INSERT, $urandom, 6'($urandom_range(63)), 8'hFF);
        default: add_item(OP_VERIFY, $urandom, 6'($urandom_range(63)), 8'hFF);
      endcase
    end
  endtask

  initial begin
    int unsigned i;
    route_req_t kr;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, then single routes, odd root entries and length saturation
    add_item(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
    add_item(OP_VERIFY, 32'hFFFF_FFFF, 6'd32, 8'd0);
    add_item(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd254);
    add_item(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'd255);
    add_item(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0);
    add_item(OP_VERIFY, 32'hFFFF_FFFF, 6'd32, 8'd254);
    add_item(OP_VERIFY, 32'hFFFF_FFFF, 6'd32, 8'd1);
    add_item(OP_VERIFY, 32'hFFFF_FFFF, 6'd30, 8'd254);
    add_item(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd3);
    add_item(OP_INSERT, 32'h8000_0000, 6'd1, 8'd0);
    add_item(OP_INSERT, 32'h0000_0000, 6'd1, 8'd5);
    add_item(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
    add_item(OP_LOOKUP, 32'hBFFF_FFFF, 6'd0, 8'd0);
    add_item(OP_INSERT, 32'h1234_5678, 6'd63, 8'd9);
    add_item(OP_VERIFY, 32'h1234_5678, 6'd32, 8'd9);
    add_item(OP_INSERT, 32'h1234_5678, 6'd33, 8'd1);
    add_item(OP_INSERT, 32'hABCD_EF01, 6'd17, 8'hFF);
    add_item(OP_VERIFY, 32'h8000_0000, 6'd1, 8'hFF);
    add_item(OP_INVALID, 32'hFFFF_FFFF, 6'd63, 8'hFF);
    add_item(OP_INSERT, 32'hC000_0000, 6'd2, 8'd100);
    add_item(OP_LOOKUP, 32'hC000_0001, 6'd5, 8'd7);
    add_item(OP_INSERT, 32'hFFFF_FFFE, 6'd31, 8'd2);
    add_item(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'd0);
    add_item(OP_VERIFY, 32'hFFFF_FFFE, 6'd31, 8'd2);

    // default route only appears halfway, so early lookups can miss
    for (i = 0; i < 1600; i++) begin
      if (i == 800) begin
        add_item(OP_INSERT, 32'h0, 6'd0, 8'd0);
        add_item(OP_VERIFY, $urandom, 6'd0, 8'd0);
      end
      add_random(i >= 800);
    end
    wait_drained();

    for (i = 0; i < 40; i++) begin
      kr = known_routes[$urandom_range(known_routes.size() - 1)];
      case ($urandom_range(4))
        0: add_item(OP_INSERT, $urandom, pick_len(1'b1), 8'($urandom_range(254)));
        1: add_item(OP_INSERT, kr.addr, kr.len, kr.port);
        2: add_item(OP_INSERT, $urandom, 6'($urandom_range(63)), 8'hFF);
        3: add_item(OP_LOOKUP, near_addr(kr), 6'($urandom_range(63)),
                    8'($urandom_range(255)));
        default: add_item(OP_VERIFY, kr.addr, kr.len, kr.port);
      endcase
    end
    wait_drained();
    repeat (40) @(posedge clk);

    $display("%0d items sent (insert %0d, lookup %0d, verify %0d, other %0d), %0d trie nodes used",
             accepted_items, ops_sent[OP_INSERT], ops_sent[OP_LOOKUP], ops_sent[OP_VERIFY],
             ops_sent[OP_INVALID], alloc_count);
    $display("%0d results: ok %0d, duplicate %0d, full %0d, none %0d",
             checked_results, status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_NONE]);
    if (want_q.size() != 0) begin
      $display("%0d expected results never arrived", want_q.size());
    end
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 2_000_000);
    $display("timeout with %0d results outstanding", want_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

[stride2_trie_prefix_match_unit.f]
+incdir+rtl
rtl/stpm_pkg.sv
rtl/stpm_node_mem.sv
rtl/stride2_trie_prefix_match_unit.sv
tb/tb.sv
